>>> design/ncst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncst_pkg
// Types and constants shared by the neighbor cache state table modules.
// ----------------------------------------------------------------------------
package ncst_pkg;

    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned FIFO_DEPTH  = 16;
    localparam int unsigned FIFO_PTR_W  = 4;
    localparam int unsigned FIFO_CNT_W  = 5;
    localparam int unsigned IDX_W       = 6;   // slot index, covers up to 64 slots
    localparam int unsigned CNT_W       = 4;   // results so far, 0..MAX_RESULTS

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_REPLY  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } ncst_op_t;

    typedef enum logic [2:0] {
        PH_STALE      = 3'd0,
        PH_REACHABLE  = 3'd1,
        PH_PROBE      = 3'd2,
        PH_INCOMPLETE = 3'd3,
        PH_DELAY      = 3'd4
    } ncst_phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_SEND     = 3'd1,
        EV_DROP     = 3'd2,
        EV_HELD     = 3'd3,
        EV_REQUEST  = 3'd4,
        EV_TRANSMIT = 3'd5
    } ncst_event_t;

    typedef enum logic [2:0] {
        CFG_REACHABLE_TICKS    = 3'd0,
        CFG_PROBE_TICKS        = 3'd1,
        CFG_PROBE_RETRIES      = 3'd2,
        CFG_INCOMPLETE_TICKS   = 3'd3,
        CFG_INCOMPLETE_RETRIES = 3'd4
    } ncst_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAIN,
        ST_SECOND,
        ST_FINISH
    } ncst_state_t;

    typedef enum logic {
        TK_TICK,
        TK_SCAN
    } ncst_tok_kind_t;

    typedef struct packed {
        logic [7:0] reachable_ticks;
        logic [7:0] probe_ticks;
        logic [7:0] probe_retries;
        logic [7:0] incomplete_ticks;
        logic [7:0] incomplete_retries;
    } ncst_cfg_t;

    // Token walking the cell row, one cell per cycle.
    typedef struct packed {
        logic           valid;
        ncst_tok_kind_t kind;
        logic [31:0]    ip;
        logic [CNT_W-1:0] count;
        logic           found;
        logic [IDX_W-1:0] fidx;
        ncst_phase_t    fphase;
        logic [47:0]    fmac;
        logic           fheld;
        logic [7:0]     ftag;
        logic           efound;
        logic [IDX_W-1:0] eidx;
        logic           sfound;
        logic [IDX_W-1:0] sidx;
    } ncst_token_t;

    // Slot write issued after a scan.
    typedef struct packed {
        logic           valid;
        logic [IDX_W-1:0] idx;
        logic           wr_ip;
        logic [31:0]    ip;
        logic           wr_mac;
        logic [47:0]    mac;
        ncst_phase_t    phase;
        logic [7:0]     timer;
        logic [7:0]     retries;
        logic           held;
        logic           wr_tag;
        logic [7:0]     tag;
    } ncst_cmd_t;

    typedef struct packed {
        logic        valid;
        ncst_event_t kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        uni;
        logic [7:0]  tag;
    } ncst_res_t;

    typedef struct packed {
        ncst_event_t kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        uni;
        logic [7:0]  tag;
        logic        last;
    } ncst_item_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  full;
    } ncst_fifo_stat_t;

    function automatic ncst_res_t mk_res(ncst_event_t kind, logic [31:0] ip,
                                         logic [47:0] mac, logic uni, logic [7:0] tag);
        ncst_res_t r;
        r.valid = 1'b1;
        r.kind  = kind;
        r.ip    = ip;
        r.mac   = mac;
        r.uni   = uni;
        r.tag   = tag;
        return r;
    endfunction

endpackage

>>> design/ncst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncst_cell
// One table slot: ages itself or matches a scan token as it passes.
// ----------------------------------------------------------------------------
module ncst_cell
    import ncst_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ncst_cfg_t   cfg,
    input  ncst_cmd_t   cmd_i,
    input  ncst_token_t tok_i,
    output ncst_token_t tok_o,
    output ncst_res_t   res_o
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [31:0] ip_reg, ip_next;
    logic [47:0] mac_reg, mac_next;
    ncst_phase_t phase_reg, phase_next;
    logic [7:0]  timer_reg, timer_next;
    logic [7:0]  retries_reg, retries_next;
    logic        held_reg, held_next;
    logic [7:0]  tag_reg, tag_next;
    ncst_token_t tok_reg, tok_next;
    ncst_res_t   res_reg, res_next;

    always_comb begin
        ip_next      = ip_reg;
        mac_next     = mac_reg;
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        retries_next = retries_reg;
        held_next    = held_reg;
        tag_next     = tag_reg;
        tok_next     = tok_i;
        res_next     = '0;

        if (cmd_i.valid && cmd_i.idx == MY_IDX) begin
            if (cmd_i.wr_ip) begin
                ip_next = cmd_i.ip;
            end
            if (cmd_i.wr_mac) begin
                mac_next = cmd_i.mac;
            end
            if (cmd_i.wr_tag) begin
                tag_next = cmd_i.tag;
            end
            phase_next   = cmd_i.phase;
            timer_next   = cmd_i.timer;
            retries_next = cmd_i.retries;
            held_next    = cmd_i.held;
        end

        if (tok_i.valid) begin
            unique case (tok_i.kind)
                TK_SCAN: begin
                    if (!tok_i.found && ip_reg == tok_i.ip) begin
                        tok_next.found  = 1'b1;
                        tok_next.fidx   = MY_IDX;
                        tok_next.fphase = phase_reg;
                        tok_next.fmac   = mac_reg;
                        tok_next.fheld  = held_reg;
                        tok_next.ftag   = tag_reg;
                    end
                    if (!tok_i.efound && ip_reg == 32'd0) begin
                        tok_next.efound = 1'b1;
                        tok_next.eidx   = MY_IDX;
                    end
                    if (!tok_i.sfound && phase_reg == PH_STALE) begin
                        tok_next.sfound = 1'b1;
                        tok_next.sidx   = MY_IDX;
                    end
                end
                TK_TICK: begin
                    if (ip_reg != 32'd0 && tok_i.count < CNT_W'(MAX_RESULTS)) begin
                        priority case (phase_reg)
                            PH_REACHABLE: begin
                                if (timer_reg <= 8'd1) begin
                                    phase_next   = PH_PROBE;
                                    timer_next   = cfg.probe_ticks;
                                    retries_next = cfg.probe_retries;
                                    held_next    = 1'b0;
                                end else begin
                                    timer_next = timer_reg - 8'd1;
                                end
                            end
                            PH_INCOMPLETE: begin
                                if (timer_reg <= 8'd1) begin
                                    timer_next = 8'd0;
                                    if (retries_reg <= 8'd1) begin
                                        retries_next = 8'd0;
                                        ip_next      = 32'd0;
                                        if (held_reg) begin
                                            held_next = 1'b0;
                                            res_next  = mk_res(EV_DROP, ip_reg, 48'd0,
                                                               1'b0, tag_reg);
                                        end
                                    end else begin
                                        retries_next = retries_reg - 8'd1;
                                        timer_next   = cfg.incomplete_ticks;
                                        res_next     = mk_res(EV_REQUEST, ip_reg, 48'd0,
                                                              1'b0, 8'd0);
                                    end
                                end else begin
                                    timer_next = timer_reg - 8'd1;
                                end
                            end
                            PH_PROBE: begin
                                if (timer_reg <= 8'd1) begin
                                    if (retries_reg <= 8'd1) begin
                                        phase_next   = PH_INCOMPLETE;
                                        timer_next   = cfg.incomplete_ticks;
                                        retries_next = cfg.incomplete_retries;
                                        held_next    = 1'b0;
                                    end else begin
                                        retries_next = retries_reg - 8'd1;
                                        timer_next   = cfg.probe_ticks;
                                        res_next     = mk_res(EV_REQUEST, ip_reg, mac_reg,
                                                              1'b1, 8'd0);
                                    end
                                end else begin
                                    timer_next = timer_reg - 8'd1;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (res_next.valid) begin
                            tok_next.count = tok_i.count + CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg      <= '0;
            mac_reg     <= '0;
            phase_reg   <= PH_STALE;
            timer_reg   <= '0;
            retries_reg <= '0;
            held_reg    <= 1'b0;
            tok_reg     <= '0;
            res_reg     <= '0;
        end else begin
            ip_reg      <= ip_next;
            mac_reg     <= mac_next;
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            retries_reg <= retries_next;
            held_reg    <= held_next;
            tok_reg     <= tok_next;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
    end

    assign tok_o = tok_reg;
    assign res_o = res_reg;

endmodule

>>> design/ncst_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncst_fifo
// Result queue between the cell row and the result channel.
// ----------------------------------------------------------------------------
module ncst_fifo
    import ncst_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ncst_item_t      push_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ncst_item_t      out_data,
    output ncst_fifo_stat_t stat
);

    ncst_item_t mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_reg, wr_next;
    logic [FIFO_PTR_W-1:0] rd_reg, rd_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + FIFO_PTR_W'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + FIFO_PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign stat.count = cnt_reg;
    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

>>> design/neighbor_cache_state_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_cache_state_table
// IPv4 neighbor cache built as a row of slot cells with a scan controller.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per beat. tuser carries the opcode (tick, reply,
//   lookup); tdata carries address, MAC, solicited flag and packet tag.
//   m_axis: result events, tuser the event kind, tlast on the final result
//   of each request. Every request yields at least one result.
//   cfg: register index and 8-bit value, always ready; write only while idle.
// Timing: a tick or a scan token walks the row of ENTRIES cells, one cell per
//   cycle, then the request finishes; a lookup that inserts an entry also
//   sends a second result. Zero-address and unused requests skip the row.
//   One request is worked on at a time; the cell row sets the rate.
// Results go through a 16-deep queue; the next request is taken as soon as
//   the controller is idle and eight free places remain, so a stalled
//   receiver holds new requests off once more than eight results wait.
// Reset: all slots empty and stale, registers at 40/3/4/3/4, queue empty.
// ----------------------------------------------------------------------------
module neighbor_cache_state_table
    import ncst_pkg::*;
#(
    parameter int unsigned ENTRIES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // ip_address, mac_in, solicited, packet_tag
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // ip_out, mac_out, unicast, tag_out
    output logic [2:0]  m_axis_tuser,   // event_kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    ncst_cfg_t   cfg_reg;
    ncst_state_t state_reg, state_next;
    ncst_op_t    op_reg, op_next;
    logic [31:0] ip_reg, ip_next;
    logic [47:0] mac_reg, mac_next;
    logic        sol_reg, sol_next;
    logic [7:0]  tag_reg, tag_next;
    ncst_res_t   pend_reg, pend_next;
    ncst_res_t   second_reg, second_next;
    ncst_cmd_t   cmd_reg, cmd_next;
    ncst_token_t inj_reg, inj_next;

    ncst_token_t chain [ENTRIES+1];
    ncst_res_t   cell_res [ENTRIES];
    logic [ENTRIES-1:0] res_vld;
    ncst_res_t   row_res;
    ncst_token_t tok_out;

    logic            s_accept;
    logic            push;
    ncst_item_t      push_data;
    ncst_item_t      q_data;
    ncst_fifo_stat_t q_stat;
    ncst_op_t        in_op;
    logic [31:0]     in_ip;
    ncst_res_t       new_res;
    logic [IDX_W-1:0] slot_idx;
    logic            slot_ok;

    assign cfg_ready = 1'b1;
    assign in_op     = ncst_op_t'(s_axis_tuser);
    assign in_ip     = s_axis_tdata[31:0];

    // Take a request only when idle and a full tick's worth of queue is free.
    assign s_axis_tready = (state_reg == ST_IDLE) &&
                           (q_stat.count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // Row of slot cells; the token enters at cell 0 and leaves the last cell.
    assign chain[0] = inj_reg;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ncst_cell #(.CELL_IDX(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cfg     (cfg_reg),
            .cmd_i   (cmd_reg),
            .tok_i   (chain[g]),
            .tok_o   (chain[g+1]),
            .res_o   (cell_res[g])
        );
        assign res_vld[g] = cell_res[g].valid;
    end
    assign tok_out = chain[ENTRIES];

    // At most one cell holds the token, so at most one result is valid.
    always_comb begin
        row_res = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (cell_res[i].valid) begin
                row_res = cell_res[i];
            end
        end
    end

    // Slot for a new entry: first empty, else first stale.
    assign slot_ok  = tok_out.efound || tok_out.sfound;
    assign slot_idx = tok_out.efound ? tok_out.eidx : tok_out.sidx;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        ip_next     = ip_reg;
        mac_next    = mac_reg;
        sol_next    = sol_reg;
        tag_next    = tag_reg;
        pend_next   = pend_reg;
        second_next = second_reg;
        cmd_next    = '0;
        inj_next    = '0;
        new_res     = '0;
        push        = 1'b0;
        push_data   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next  = in_op;
                    ip_next  = in_ip;
                    mac_next = s_axis_tdata[79:32];
                    sol_next = s_axis_tdata[80];
                    tag_next = s_axis_tdata[88:81];
                    priority if (in_op == OP_TICK) begin
                        inj_next.valid = 1'b1;
                        inj_next.kind  = TK_TICK;
                        state_next     = ST_CHAIN;
                    end else if ((in_op == OP_REPLY || in_op == OP_LOOKUP) &&
                                 in_ip != 32'd0) begin
                        inj_next.valid = 1'b1;
                        inj_next.kind  = TK_SCAN;
                        inj_next.ip    = in_ip;
                        state_next     = ST_CHAIN;
                    end else if (in_op == OP_LOOKUP) begin
                        // Lookup of address zero: drop the packet.
                        new_res    = mk_res(EV_DROP, 32'd0, 48'd0, 1'b0,
                                            s_axis_tdata[88:81]);
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CHAIN: begin
                new_res = row_res;
                if (tok_out.valid) begin
                    state_next = ST_FINISH;
                    if (tok_out.kind == TK_SCAN) begin
                        if (op_reg == OP_REPLY) begin
                            if (tok_out.found) begin
                                if (sol_reg && (tok_out.fphase == PH_INCOMPLETE ||
                                                tok_out.fphase == PH_PROBE)) begin
                                    cmd_next.valid  = 1'b1;
                                    cmd_next.idx    = tok_out.fidx;
                                    cmd_next.wr_mac = 1'b1;
                                    cmd_next.mac    = mac_reg;
                                    cmd_next.phase  = PH_REACHABLE;
                                    cmd_next.timer  = cfg_reg.reachable_ticks;
                                    cmd_next.tag    = tok_out.ftag;
                                    if (tok_out.fheld) begin
                                        new_res = mk_res(EV_TRANSMIT, ip_reg, mac_reg,
                                                         1'b0, tok_out.ftag);
                                    end
                                end
                            end else if (slot_ok) begin
                                cmd_next.valid  = 1'b1;
                                cmd_next.idx    = slot_idx;
                                cmd_next.wr_ip  = 1'b1;
                                cmd_next.ip     = ip_reg;
                                cmd_next.wr_mac = 1'b1;
                                cmd_next.mac    = mac_reg;
                                cmd_next.phase  = PH_STALE;
                            end
                        end else begin
                            if (tok_out.found) begin
                                if (tok_out.fphase == PH_INCOMPLETE) begin
                                    new_res = mk_res(EV_DROP, ip_reg, 48'd0, 1'b0, tag_reg);
                                end else begin
                                    if (tok_out.fphase == PH_STALE) begin
                                        cmd_next.valid   = 1'b1;
                                        cmd_next.idx     = tok_out.fidx;
                                        cmd_next.phase   = PH_PROBE;
                                        cmd_next.timer   = cfg_reg.probe_ticks;
                                        cmd_next.retries = cfg_reg.probe_retries;
                                    end
                                    new_res = mk_res(EV_SEND, ip_reg, tok_out.fmac, 1'b0,
                                                     tag_reg);
                                end
                            end else if (slot_ok) begin
                                cmd_next.valid   = 1'b1;
                                cmd_next.idx     = slot_idx;
                                cmd_next.wr_ip   = 1'b1;
                                cmd_next.ip      = ip_reg;
                                cmd_next.wr_mac  = 1'b1;
                                cmd_next.phase   = PH_INCOMPLETE;
                                cmd_next.timer   = cfg_reg.incomplete_ticks;
                                cmd_next.retries = cfg_reg.incomplete_retries;
                                cmd_next.held    = 1'b1;
                                cmd_next.wr_tag  = 1'b1;
                                cmd_next.tag     = tag_reg;
                                new_res     = mk_res(EV_REQUEST, ip_reg, 48'd0, 1'b0, 8'd0);
                                second_next = mk_res(EV_HELD, ip_reg, 48'd0, 1'b0, tag_reg);
                                state_next  = ST_SECOND;
                            end else begin
                                new_res = mk_res(EV_DROP, ip_reg, 48'd0, 1'b0, tag_reg);
                            end
                        end
                    end
                end
            end
            ST_SECOND: begin
                new_res    = second_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Flush the held result as the last one, or report none.
                push = 1'b1;
                if (pend_reg.valid) begin
                    push_data = {pend_reg.kind, pend_reg.ip, pend_reg.mac,
                                 pend_reg.uni, pend_reg.tag, 1'b1};
                end else begin
                    push_data      = '0;
                    push_data.kind = EV_NONE;
                    push_data.last = 1'b1;
                end
                pend_next  = '0;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Hold each result one step so the final one can carry tlast.
        if (new_res.valid) begin
            if (pend_reg.valid) begin
                push      = 1'b1;
                push_data = {pend_reg.kind, pend_reg.ip, pend_reg.mac,
                             pend_reg.uni, pend_reg.tag, 1'b0};
            end
            pend_next = new_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pend_reg   <= '0;
            second_reg <= '0;
            cmd_reg    <= '0;
            inj_reg    <= '0;
            op_reg     <= OP_TICK;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            second_reg <= second_next;
            cmd_reg    <= cmd_next;
            inj_reg    <= inj_next;
            op_reg     <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        ip_reg  <= ip_next;
        mac_reg <= mac_next;
        sol_reg <= sol_next;
        tag_reg <= tag_next;
    end

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reachable_ticks    <= 8'd40;
            cfg_reg.probe_ticks        <= 8'd3;
            cfg_reg.probe_retries      <= 8'd4;
            cfg_reg.incomplete_ticks   <= 8'd3;
            cfg_reg.incomplete_retries <= 8'd4;
        end else if (cfg_valid && cfg_ready) begin
            priority case (cfg_index)
                CFG_REACHABLE_TICKS:    cfg_reg.reachable_ticks    <= cfg_data;
                CFG_PROBE_TICKS:        cfg_reg.probe_ticks        <= cfg_data;
                CFG_PROBE_RETRIES:      cfg_reg.probe_retries      <= cfg_data;
                CFG_INCOMPLETE_TICKS:   cfg_reg.incomplete_ticks   <= cfg_data;
                CFG_INCOMPLETE_RETRIES: cfg_reg.incomplete_retries <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ncst_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (q_data),
        .stat      (q_stat)
    );

    assign m_axis_tdata = {7'd0, q_data.tag, q_data.uni, q_data.mac, q_data.ip};
    assign m_axis_tuser = q_data.kind;
    assign m_axis_tlast = q_data.last;

    // Queue space is reserved at accept, so a push never meets a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("result queue overflow");

    // Only the cell holding the token may report.
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(res_vld))
        else $error("more than one cell result at once");

    // The token leaves the row only while the controller waits for it.
    a_token_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_out.valid |-> state_reg == ST_CHAIN)
        else $error("token left the row outside a walk");

    // A slot write follows only a scan that just finished.
    a_cmd_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg.valid |-> $past(state_reg) == ST_CHAIN)
        else $error("slot write without a scan");

endmodule
